[hw/rtl/pcts_pkg.sv]
// Shared widths, thresholds, register addresses and codes for the pulse count tick sequencer.
// No dependencies.

package pcts_pkg;

    localparam int unsigned COUNT_W = 16;
    localparam int unsigned RATE_W  = 20;
    localparam int unsigned BIN_W   = 20;
    localparam int unsigned DOSE_W  = 32;
    localparam int unsigned BEEP_W  = 3;
    localparam int unsigned RUN_W   = 5;
    localparam int unsigned IDLE_W  = 24;
    localparam int unsigned PDS_W   = 16;
    localparam int unsigned PHASE_W = 5;
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    // idle thresholds in half-second ticks
    localparam logic [IDLE_W-1:0] IDLE_FULL_DRAW = 24'd3600;
    localparam logic [IDLE_W-1:0] IDLE_HALF_DRAW = 24'd14400;
    localparam logic [IDLE_W-1:0] IDLE_IND_OFF   = 24'd21600;
    localparam logic [IDLE_W-1:0] IDLE_BACKLIGHT = 24'd1200;

    localparam logic [RATE_W-1:0] RATE_LOW = 20'd1000;
    localparam logic [RATE_W-1:0] RATE_MID = 20'd10000;

    localparam logic [RUN_W-1:0] RUN_BATT_LIMIT = 5'd10;
    localparam logic [RUN_W-1:0] RUN_ALARM_MIN  = 5'd20;

    // phase is kept modulo 20; a minute is six of these cycles
    localparam logic [PHASE_W-1:0] PHASE_LAST = 5'd19;
    localparam logic [PHASE_W-1:0] PHASE_HALF = 5'd10;

    localparam logic [BEEP_W-1:0] BEEP_NONE = 3'd0;
    localparam logic [BEEP_W-1:0] BEEP_LOW  = 3'd2;
    localparam logic [BEEP_W-1:0] BEEP_MID  = 3'd3;
    localparam logic [BEEP_W-1:0] BEEP_HIGH = 3'd4;

    typedef enum logic [PADDR_W-1:0] {
        ADDR_ALARM_EN  = 4'h0,
        ADDR_ALARM_THR = 4'h4,
        ADDR_PD_EN     = 4'h8,
        ADDR_PD_SECS   = 4'hC
    } cfg_addr_t;

endpackage

[hw/rtl/pcts_if.sv]
// Valid/ready channels for tick requests and result requests.
// Depends on pcts_pkg.

interface pcts_tick_if;
    logic                          valid;
    logic                          ready;
    logic [pcts_pkg::COUNT_W-1:0]  pulse_count;
    logic [pcts_pkg::RATE_W-1:0]   rate_level;
    logic                          button_activity;

    modport source (output valid, pulse_count, rate_level, button_activity, input ready);
    modport sink   (input valid, pulse_count, rate_level, button_activity, output ready);
endinterface

interface pcts_result_if;
    logic                          valid;
    logic                          ready;
    logic                          draw_request;
    logic                          indicators_off;
    logic                          power_down;
    logic                          backlight_off;
    logic                          battery_measure;
    logic                          generator_start;
    logic [pcts_pkg::BEEP_W-1:0]   beep_count;
    logic                          bin_valid;
    logic [pcts_pkg::BIN_W-1:0]    bin_sum;
    logic [pcts_pkg::DOSE_W-1:0]   dose_total;

    modport source (output valid, draw_request, indicators_off, power_down, backlight_off,
                    battery_measure, generator_start, beep_count, bin_valid, bin_sum,
                    dose_total, input ready);
    modport sink   (input valid, draw_request, indicators_off, power_down, backlight_off,
                    battery_measure, generator_start, beep_count, bin_valid, bin_sum,
                    dose_total, output ready);
endinterface

[hw/rtl/pulse_count_tick_sequencer.sv]
// Top level: tick sequencer with long-ring bin memory, dose total and timer requests.
// Depends on pcts_pkg and pcts_if.
//
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+-------------------------------------------
// tick     | in  | valid/ready        | pulse_count, rate_level, button_activity
// result   | out | valid/ready        | request flags, beep_count, bin, dose_total
// apb      | in  | psel/penable/pready| 4 registers at 0x0, 0x4, 0x8, 0xC
//
// One tick per cycle unless the result stalls; a tick passes the add stage, then the
// result register. Bin memory: read at acceptance, add and write back in the add
// stage; the last write is forwarded to the following tick. A fresh-bin flag stands
// in for clearing. No clearing pass: the block is ready straight out of reset.
// A stalled result holds one further tick in the add stage.

module pulse_count_tick_sequencer #(
    parameter int unsigned SHORT_DEPTH = 120,
    parameter int unsigned LONG_DEPTH  = 200,
    parameter int unsigned BIN_TICKS   = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    pcts_tick_if.sink                     tick,
    pcts_result_if.source                 result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcts_pkg::PADDR_W-1:0]  paddr,
    input  logic [pcts_pkg::PDATA_W-1:0]  pwdata,
    output logic [pcts_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int unsigned SI_W = $clog2(SHORT_DEPTH);
    localparam int unsigned LI_W = (LONG_DEPTH > 1) ? $clog2(LONG_DEPTH) : 1;
    localparam int unsigned BP_W = (BIN_TICKS > 1) ? $clog2(BIN_TICKS) : 1;

    // configuration
    logic                          alarm_en_reg;
    logic [pcts_pkg::RATE_W-1:0]   alarm_thr_reg;
    logic                          pd_en_reg;
    logic [pcts_pkg::PDS_W-1:0]    pd_secs_reg;
    logic                          cfg_wr;

    // tick state
    logic [SI_W-1:0]               short_idx_reg,  short_idx_next;
    logic [BP_W-1:0]               bin_pos_reg,    bin_pos_next;
    logic [LI_W-1:0]               long_idx_reg,   long_idx_next;
    logic                          fresh_reg;
    logic [pcts_pkg::DOSE_W-1:0]   dose_reg,       dose_next;
    logic [pcts_pkg::PHASE_W-1:0]  phase_reg,      phase_next;
    logic [pcts_pkg::RUN_W-1:0]    run_reg,        run_next;
    logic [pcts_pkg::IDLE_W-1:0]   idle_reg,       idle_next;

    logic                          tick_acc;
    logic [pcts_pkg::IDLE_W-1:0]   idle_eff;
    logic                          short_last;
    logic                          bin_end;
    logic [pcts_pkg::DOSE_W:0]     dose_sum;
    logic                          draw, ind_off, pdown, blight, batt, gen;
    logic [pcts_pkg::BEEP_W-1:0]   beeps;

    // add stage
    logic                          s1_valid_reg;
    logic [pcts_pkg::COUNT_W-1:0]  s1_count_reg;
    logic [LI_W-1:0]               s1_addr_reg;
    logic                          s1_fresh_reg;
    logic                          s1_bin_end_reg;
    logic                          s1_draw_reg, s1_ind_off_reg, s1_pdown_reg;
    logic                          s1_blight_reg, s1_batt_reg, s1_gen_reg;
    logic [pcts_pkg::BEEP_W-1:0]   s1_beeps_reg;
    logic [pcts_pkg::DOSE_W-1:0]   s1_dose_reg;
    logic                          s1_adv;
    logic                          mem_we;

    // bin memory and forwarding
    logic [pcts_pkg::BIN_W-1:0]    ring_mem [LONG_DEPTH];
    logic [pcts_pkg::BIN_W-1:0]    rd_data_reg;
    logic [LI_W-1:0]               fwd_addr_reg;
    logic [pcts_pkg::BIN_W-1:0]    fwd_data_reg;
    logic [pcts_pkg::BIN_W-1:0]    bin_base;
    logic [pcts_pkg::BIN_W:0]      bin_add;
    logic [pcts_pkg::BIN_W-1:0]    bin_new;

    // result register
    logic                          res_valid_reg;
    logic                          res_draw_reg, res_ind_off_reg, res_pdown_reg;
    logic                          res_blight_reg, res_batt_reg, res_gen_reg;
    logic [pcts_pkg::BEEP_W-1:0]   res_beeps_reg;
    logic                          res_bin_valid_reg;
    logic [pcts_pkg::BIN_W-1:0]    res_bin_sum_reg;
    logic [pcts_pkg::DOSE_W-1:0]   res_dose_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_en_reg  <= 1'b0;
            alarm_thr_reg <= '0;
            pd_en_reg     <= 1'b0;
            pd_secs_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr)
                pcts_pkg::ADDR_ALARM_EN:  alarm_en_reg  <= pwdata[0];
                pcts_pkg::ADDR_ALARM_THR: alarm_thr_reg <= pwdata[pcts_pkg::RATE_W-1:0];
                pcts_pkg::ADDR_PD_EN:     pd_en_reg     <= pwdata[0];
                pcts_pkg::ADDR_PD_SECS:   pd_secs_reg   <= pwdata[pcts_pkg::PDS_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            pcts_pkg::ADDR_ALARM_EN:  prdata = pcts_pkg::PDATA_W'(alarm_en_reg);
            pcts_pkg::ADDR_ALARM_THR: prdata = pcts_pkg::PDATA_W'(alarm_thr_reg);
            pcts_pkg::ADDR_PD_EN:     prdata = pcts_pkg::PDATA_W'(pd_en_reg);
            pcts_pkg::ADDR_PD_SECS:   prdata = pcts_pkg::PDATA_W'(pd_secs_reg);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- tick stage ----------------
    assign s1_adv     = !res_valid_reg || result.ready;
    assign tick.ready = !s1_valid_reg || s1_adv;
    assign tick_acc   = tick.valid && tick.ready;

    assign idle_eff   = tick.button_activity ? '0 : idle_reg;
    assign short_last = (short_idx_reg == SI_W'(SHORT_DEPTH - 1));
    assign bin_end    = short_last || (bin_pos_reg == BP_W'(BIN_TICKS - 1));

    always_comb
    begin
        short_idx_next = short_last ? '0 : short_idx_reg + 1'b1;
        bin_pos_next   = bin_end ? '0 : bin_pos_reg + 1'b1;
        long_idx_next  = long_idx_reg;
        if (bin_end)
        begin
            long_idx_next = (long_idx_reg == LI_W'(LONG_DEPTH - 1)) ? '0 : long_idx_reg + 1'b1;
        end

        dose_sum  = {1'b0, dose_reg} + (pcts_pkg::DOSE_W + 1)'(tick.pulse_count);
        dose_next = dose_sum[pcts_pkg::DOSE_W] ? '1 : dose_sum[pcts_pkg::DOSE_W-1:0];

        phase_next = (phase_reg == pcts_pkg::PHASE_LAST) ? '0 : phase_reg + 1'b1;
        run_next   = (run_reg == '1) ? run_reg : run_reg + 1'b1;
        idle_next  = (idle_eff == '1) ? idle_eff : idle_eff + 1'b1;

        if (idle_eff < pcts_pkg::IDLE_FULL_DRAW)
            draw = 1'b1;
        else if (idle_eff < pcts_pkg::IDLE_HALF_DRAW)
            draw = !phase_reg[0];
        else
            draw = (phase_reg == '0);

        ind_off = (idle_eff > pcts_pkg::IDLE_IND_OFF);
        pdown   = pd_en_reg && (idle_eff > pcts_pkg::IDLE_W'({pd_secs_reg, 1'b0}));
        blight  = (idle_eff == pcts_pkg::IDLE_BACKLIGHT);
        batt    = (run_reg < pcts_pkg::RUN_BATT_LIMIT) || (phase_reg == '0);
        gen     = (phase_reg == '0) || (phase_reg == pcts_pkg::PHASE_HALF);

        beeps = pcts_pkg::BEEP_NONE;
        if (gen && (run_reg > pcts_pkg::RUN_ALARM_MIN) && alarm_en_reg
            && (tick.rate_level > alarm_thr_reg))
        begin
            if (tick.rate_level < pcts_pkg::RATE_LOW)
                beeps = pcts_pkg::BEEP_LOW;
            else if (tick.rate_level < pcts_pkg::RATE_MID)
                beeps = pcts_pkg::BEEP_MID;
            else
                beeps = pcts_pkg::BEEP_HIGH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_idx_reg <= '0;
            bin_pos_reg   <= '0;
            long_idx_reg  <= '0;
            fresh_reg     <= 1'b1;
            dose_reg      <= '0;
            phase_reg     <= '0;
            run_reg       <= '0;
            idle_reg      <= '0;
        end
        else if (tick_acc)
        begin
            short_idx_reg <= short_idx_next;
            bin_pos_reg   <= bin_pos_next;
            long_idx_reg  <= long_idx_next;
            fresh_reg     <= bin_end;
            dose_reg      <= dose_next;
            phase_reg     <= phase_next;
            run_reg       <= run_next;
            idle_reg      <= idle_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (tick_acc)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            s1_count_reg   <= tick.pulse_count;
            s1_addr_reg    <= long_idx_reg;
            s1_fresh_reg   <= fresh_reg;
            s1_bin_end_reg <= bin_end;
            s1_draw_reg    <= draw;
            s1_ind_off_reg <= ind_off;
            s1_pdown_reg   <= pdown;
            s1_blight_reg  <= blight;
            s1_batt_reg    <= batt;
            s1_gen_reg     <= gen;
            s1_beeps_reg   <= beeps;
            s1_dose_reg    <= dose_next;
        end
    end

    // ---------------- bin memory ----------------
    assign mem_we = s1_valid_reg && s1_adv;

    always_ff @(posedge clk)
    begin
        if (tick_acc)
            rd_data_reg <= ring_mem[long_idx_reg];
        if (mem_we)
            ring_mem[s1_addr_reg] <= bin_new;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= bin_new;
        end
    end

    // a fresh bin reads as zero; otherwise the latest write wins over the read data
    always_comb
    begin
        if (s1_fresh_reg)
            bin_base = '0;
        else if (fwd_addr_reg == s1_addr_reg)
            bin_base = fwd_data_reg;
        else
            bin_base = rd_data_reg;
        bin_add = {1'b0, bin_base} + (pcts_pkg::BIN_W + 1)'(s1_count_reg);
        bin_new = bin_add[pcts_pkg::BIN_W] ? '1 : bin_add[pcts_pkg::BIN_W-1:0];
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (s1_adv)
            res_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            res_draw_reg      <= s1_draw_reg;
            res_ind_off_reg   <= s1_ind_off_reg;
            res_pdown_reg     <= s1_pdown_reg;
            res_blight_reg    <= s1_blight_reg;
            res_batt_reg      <= s1_batt_reg;
            res_gen_reg       <= s1_gen_reg;
            res_beeps_reg     <= s1_beeps_reg;
            res_bin_valid_reg <= s1_bin_end_reg;
            res_bin_sum_reg   <= s1_bin_end_reg ? bin_new : '0;
            res_dose_reg      <= s1_dose_reg;
        end
    end

    assign result.valid           = res_valid_reg;
    assign result.draw_request    = res_draw_reg;
    assign result.indicators_off  = res_ind_off_reg;
    assign result.power_down      = res_pdown_reg;
    assign result.backlight_off   = res_blight_reg;
    assign result.battery_measure = res_batt_reg;
    assign result.generator_start = res_gen_reg;
    assign result.beep_count      = res_beeps_reg;
    assign result.bin_valid       = res_bin_valid_reg;
    assign result.bin_sum         = res_bin_sum_reg;
    assign result.dose_total      = res_dose_reg;

endmodule

[hw/rtl/pcts_checker.sv]
// Port-level checks on the result channel of the tick sequencer, with its bind.
// Depends on pcts_pkg and pulse_count_tick_sequencer.

module pcts_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic                         generator_start,
    input logic                         indicators_off,
    input logic                         backlight_off,
    input logic [pcts_pkg::BEEP_W-1:0]  beep_count,
    input logic                         bin_valid,
    input logic [pcts_pkg::BIN_W-1:0]   bin_sum
);

    // result request held until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result request dropped before it was taken");

    a_bin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !bin_valid |-> bin_sum == '0)
        else $error("bin_sum non-zero without a finished bin");

    a_beep_gen: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && beep_count != pcts_pkg::BEEP_NONE |-> generator_start)
        else $error("alarm beeps outside a generator tick");

    a_beep_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> beep_count == pcts_pkg::BEEP_NONE || beep_count == pcts_pkg::BEEP_LOW
                   || beep_count == pcts_pkg::BEEP_MID || beep_count == pcts_pkg::BEEP_HIGH)
        else $error("invalid beep count");

    a_idle_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && indicators_off |-> !backlight_off)
        else $error("backlight-off and indicators-off on the same tick");

endmodule

bind pulse_count_tick_sequencer pcts_checker u_pcts_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .generator_start (result.generator_start),
    .indicators_off  (result.indicators_off),
    .backlight_off   (result.backlight_off),
    .beep_count      (result.beep_count),
    .bin_valid       (result.bin_valid),
    .bin_sum         (result.bin_sum)
);
